[rtl/core/hdr_pkg.sv]
package hdr_pkg;

  localparam int TAB_LEN = 48;
  localparam int SQRT_ITERS = 31;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] HALF_DIFF_SCALE = 32'd2562047788;
  localparam logic [29:0] DIST_SCALE = 30'd800603472;
  localparam logic [27:0] DIST_MAX = 28'd200150868;

  typedef enum logic [1:0] {
    CFG_REF_ENABLE = 2'd0,
    CFG_REF_LAT    = 2'd1,
    CFG_REF_LON    = 2'd2
  } cfg_index_t;

  // Sign/magnitude form of the four angles, ready for phase scaling.
  typedef struct packed {
    logic        ok;
    logic        dlat_neg;
    logic [31:0] dlat_mag;
    logic        dlon_neg;
    logic [32:0] dlon_mag;
    logic        flat_neg;
    logic [30:0] flat_mag;
    logic        rlat_neg;
    logic [30:0] rlat_mag;
  } front_item_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_entry(input int unsigned i);
    case (i)
      0:  return 30'd536870912;
      1:  return 30'd316933406;
      2:  return 30'd167458907;
      3:  return 30'd85004756;
      4:  return 30'd42667331;
      5:  return 30'd21354465;
      6:  return 30'd10679838;
      7:  return 30'd5340245;
      8:  return 30'd2670163;
      9:  return 30'd1335087;
      10: return 30'd667544;
      11: return 30'd333772;
      12: return 30'd166886;
      13: return 30'd83443;
      14: return 30'd41722;
      15: return 30'd20861;
      16: return 30'd10430;
      17: return 30'd5215;
      18: return 30'd2608;
      19: return 30'd1304;
      20: return 30'd652;
      21: return 30'd326;
      22: return 30'd163;
      23: return 30'd81;
      24: return 30'd41;
      25: return 30'd20;
      26: return 30'd10;
      27: return 30'd5;
      28: return 30'd3;
      29: return 30'd1;
      30: return 30'd1;
      default: return 30'd0;
    endcase
  endfunction

endpackage

[rtl/core/haversine_distance_to_reference.sv]
// Channel  Direction  Contents
// in_      request    tdata: fix_lat[30:0], fix_lon[62:31]; tuser: fix_ok
// out_     result     tdata: distance_dm[27:0]; tuser: distance_valid
// cfg_     write      cfg_addr: register index; cfg_data: value
//
// One fix per cycle is accepted while the queue has room; each result passes
// through the two CORDIC pipelines and the 31-step square root stages.
// Reset (rst_n, synchronous) clears the reference registers and all valid bits.
// A stalled output freezes the back pipeline; a four-entry queue keeps taking
// fixes until it fills. Configuration writes are always taken.
module haversine_distance_to_reference #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // fix_lat[30:0], fix_lon[62:31], zero
  input  logic [0:0]  in_tuser,   // fix_ok
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // distance_dm[27:0], zero
  output logic [0:0]  out_tuser,  // distance_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data
);

  hdr_pkg::front_item_t wr_item, rd_item;
  logic full, empty, pop, wr_en;
  logic [27:0] dist_dm;
  logic dist_valid;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign wr_en     = in_tvalid && !full;

  hdr_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .fix_lat(in_tdata[30:0]), .fix_lon(in_tdata[62:31]), .fix_ok(in_tuser[0]),
    .item(wr_item)
  );

  hdr_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_en(wr_en), .wr_item(wr_item), .full(full),
    .rd_en(pop), .rd_item(rd_item), .empty(empty)
  );

  hdr_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk(clk), .rst_n(rst_n),
    .item(rd_item), .empty(empty), .pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .dist_dm(dist_dm), .dist_valid(dist_valid)
  );

  assign out_tdata = {4'b0000, dist_dm};
  assign out_tuser = dist_valid;

endmodule

[rtl/core/hdr_front.sv]
module hdr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_addr,
  input  logic [31:0]          cfg_data,
  input  logic [30:0]          fix_lat,
  input  logic [31:0]          fix_lon,
  input  logic                 fix_ok,
  output hdr_pkg::front_item_t item
);

  logic        ref_enable_r;
  logic [30:0] ref_lat_r;
  logic [31:0] ref_lon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_enable_r <= 1'b0;
      ref_lat_r    <= '0;
      ref_lon_r    <= '0;
    end else if (cfg_valid) begin
      case (hdr_pkg::cfg_index_t'(cfg_addr))
        hdr_pkg::CFG_REF_ENABLE: ref_enable_r <= cfg_data[0];
        hdr_pkg::CFG_REF_LAT:    ref_lat_r    <= cfg_data[30:0];
        hdr_pkg::CFG_REF_LON:    ref_lon_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [31:0] dlat;
  logic signed [32:0] dlon;

  always_comb begin
    dlat = $signed({ref_lat_r[30], ref_lat_r}) - $signed({fix_lat[30], fix_lat});
    dlon = $signed({ref_lon_r[31], ref_lon_r}) - $signed({fix_lon[31], fix_lon});
    item.ok       = ref_enable_r & fix_ok;
    item.dlat_neg = dlat[31];
    item.dlat_mag = dlat[31] ? 32'(-dlat) : 32'(dlat);
    item.dlon_neg = dlon[32];
    item.dlon_mag = dlon[32] ? 33'(-dlon) : 33'(dlon);
    item.flat_neg = fix_lat[30];
    item.flat_mag = fix_lat[30] ? 31'(-fix_lat) : fix_lat;
    item.rlat_neg = ref_lat_r[30];
    item.rlat_mag = ref_lat_r[30] ? 31'(-ref_lat_r) : ref_lat_r;
  end

endmodule

[rtl/core/hdr_queue.sv]
module hdr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  hdr_pkg::front_item_t wr_item,
  output logic                 full,
  input  logic                 rd_en,
  output hdr_pkg::front_item_t rd_item,
  output logic                 empty
);

  localparam int PW = $clog2(hdr_pkg::QUEUE_DEPTH);

  hdr_pkg::front_item_t mem_r [hdr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full    = (count_r == (PW+1)'(hdr_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(hdr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(hdr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/hdr_cordic_rot.sv]
module hdr_cordic_rot #(
  parameter int STAGES = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int W = 34;
  localparam logic signed [W-1:0] ONE  = W'(64'd1073741824);
  localparam logic signed [W-1:0] HALF = W'(64'd2147483648);

  logic signed [W-1:0] x_r [STAGES+1];
  logic signed [W-1:0] y_r [STAGES+1];
  logic signed [W-1:0] z_r [STAGES+1];
  logic                flip_r [STAGES+1];

  logic signed [W-1:0] z_in, z_fold;
  logic                flip_in;

  // Fold the angle into the right half plane; the result is negated later.
  always_comb begin
    z_in    = W'($signed(phase_i));
    z_fold  = z_in;
    flip_in = 1'b0;
    if (z_in > ONE) begin
      z_fold  = z_in - HALF;
      flip_in = 1'b1;
    end else if (z_in < -ONE) begin
      z_fold  = z_in + HALF;
      flip_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= W'(hdr_pkg::GAIN_Q30);
      y_r[0]    <= '0;
      z_r[0]    <= z_fold;
      flip_r[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [W-1:0] atan_v;
    assign atan_v = $signed({{(W-30){1'b0}}, hdr_pkg::atan_entry(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_v;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_v;
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  logic signed [W-1:0] xf, yf, xc, yc;

  always_comb begin
    xf = flip_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
    yf = flip_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];
    xc = (xf > ONE) ? ONE : ((xf < -ONE) ? -ONE : xf);
    yc = (yf > ONE) ? ONE : ((yf < -ONE) ? -ONE : yf);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= yc[31:0];
      cos_o <= xc[31:0];
    end
  end

endmodule

[rtl/core/hdr_isqrt.sv]
module hdr_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] v_i,
  output logic [30:0] root_o
);

  localparam int N = hdr_pkg::SQRT_ITERS;

  logic [60:0] v_r [N+1];
  logic [61:0] r_r [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0] <= v_i;
      r_r[0] <= '0;
    end
  end

  // One result bit per stage, trial bit walking down from 2^60.
  for (genvar k = 0; k < N; k++) begin : g_iter
    logic [61:0] bit_v, trial;
    assign bit_v = 62'd1 << (60 - 2*k);
    assign trial = r_r[k] + bit_v;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, v_r[k]} >= trial) begin
          v_r[k+1] <= 61'({1'b0, v_r[k]} - trial);
          r_r[k+1] <= (r_r[k] >> 1) + bit_v;
        end else begin
          v_r[k+1] <= v_r[k];
          r_r[k+1] <= r_r[k] >> 1;
        end
      end
    end
  end

  assign root_o = r_r[N][30:0];

endmodule

[rtl/core/hdr_cordic_vec.sv]
module hdr_cordic_vec #(
  parameter int STAGES = 32
) (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] x_i,
  input  logic [30:0] y_i,
  output logic [30:0] phi_o
);

  localparam int W = 34;
  localparam logic signed [W-1:0] ONE = W'(64'd1073741824);

  logic signed [W-1:0] x_r [STAGES+1];
  logic signed [W-1:0] y_r [STAGES+1];
  logic signed [W-1:0] z_r [STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= $signed({{(W-31){1'b0}}, x_i});
      y_r[0] <= $signed({{(W-31){1'b0}}, y_i});
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [W-1:0] atan_v;
    assign atan_v = $signed({{(W-30){1'b0}}, hdr_pkg::atan_entry(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_v;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_v;
        end
      end
    end
  end

  logic signed [W-1:0] zc;

  always_comb begin
    zc = (z_r[STAGES] < 0) ? '0 : ((z_r[STAGES] > ONE) ? ONE : z_r[STAGES]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phi_o <= zc[30:0];
    end
  end

endmodule

[rtl/core/hdr_back.sv]
module hdr_back #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hdr_pkg::front_item_t item,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [27:0]          dist_dm,
  output logic                 dist_valid
);

  localparam int LC = CORDIC_STAGES + 2;
  localparam int DEPTH = 3 + LC + 4 + (hdr_pkg::SQRT_ITERS + 1) + LC + 2;

  logic             adv;
  logic [DEPTH-1:0] vld_r, ok_r;

  // The whole pipeline moves together; the queue in front soaks up stalls.
  assign adv        = !vld_r[DEPTH-1] || out_ready;
  assign pop        = adv && !empty;
  assign out_valid  = vld_r[DEPTH-1];
  assign dist_valid = ok_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r <= {ok_r[DEPTH-2:0], item.ok};
    end
  end

  // Phase scaling.
  hdr_pkg::front_item_t s0_r;
  logic [63:0] p_dlat_r;
  logic [64:0] p_dlon_r;
  logic [62:0] p_flat_r, p_rlat_r;
  logic [3:0]  neg1_r;
  logic [31:0] ph_dlat_r, ph_dlon_r, ph_flat_r, ph_rlat_r;
  logic [64:0] t_dlat, t_dlon;
  logic [63:0] t_flat, t_rlat;

  always_comb begin
    t_dlat = {1'b0, p_dlat_r} + (65'd1 << 31);
    t_dlon = p_dlon_r + (65'd1 << 31);
    t_flat = {1'b0, p_flat_r} + (64'd1 << 30);
    t_rlat = {1'b0, p_rlat_r} + (64'd1 << 30);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r      <= item;
      p_dlat_r  <= s0_r.dlat_mag * hdr_pkg::HALF_DIFF_SCALE;
      p_dlon_r  <= s0_r.dlon_mag * hdr_pkg::HALF_DIFF_SCALE;
      p_flat_r  <= s0_r.flat_mag * hdr_pkg::HALF_DIFF_SCALE;
      p_rlat_r  <= s0_r.rlat_mag * hdr_pkg::HALF_DIFF_SCALE;
      neg1_r    <= {s0_r.rlat_neg, s0_r.flat_neg, s0_r.dlon_neg, s0_r.dlat_neg};
      ph_dlat_r <= neg1_r[0] ? -t_dlat[63:32] : t_dlat[63:32];
      ph_dlon_r <= neg1_r[1] ? -t_dlon[63:32] : t_dlon[63:32];
      ph_flat_r <= neg1_r[2] ? -t_flat[62:31] : t_flat[62:31];
      ph_rlat_r <= neg1_r[3] ? -t_rlat[62:31] : t_rlat[62:31];
    end
  end

  logic signed [31:0] s_lat, s_lon, c1, c2;

  hdr_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dlat (
    .clk(clk), .en(adv), .phase_i(ph_dlat_r), .sin_o(s_lat), .cos_o()
  );
  hdr_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dlon (
    .clk(clk), .en(adv), .phase_i(ph_dlon_r), .sin_o(s_lon), .cos_o()
  );
  hdr_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_flat (
    .clk(clk), .en(adv), .phase_i(ph_flat_r), .sin_o(), .cos_o(c1)
  );
  hdr_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_rlat (
    .clk(clk), .en(adv), .phase_i(ph_rlat_r), .sin_o(), .cos_o(c2)
  );

  // Haversine term a = sin^2(dlat/2) + cos*cos*sin^2(dlon/2), all Q60.
  logic [30:0] m_slat, m_slon, m_c1, m_c2;
  logic [61:0] m_s2_r, m_u_r, m_v_r;
  logic        neg_u_r, neg_v_r;
  logic [60:0] s2_5_r, s2_6_r;
  logic signed [31:0] u_r, v_r;
  logic signed [63:0] uv_r;
  logic [61:0] r_u, r_v;
  logic signed [63:0] sum;
  logic [60:0] a_val, a_r, b_r;

  always_comb begin
    m_slat = s_lat[31] ? 31'(-s_lat) : s_lat[30:0];
    m_slon = s_lon[31] ? 31'(-s_lon) : s_lon[30:0];
    m_c1   = c1[31] ? 31'(-c1) : c1[30:0];
    m_c2   = c2[31] ? 31'(-c2) : c2[30:0];
    r_u    = m_u_r + (62'd1 << 29);
    r_v    = m_v_r + (62'd1 << 29);
    sum    = $signed({3'b000, s2_6_r}) + uv_r;
    if (sum < 0) begin
      a_val = '0;
    end else if (sum > $signed(64'd1 << 60)) begin
      a_val = 61'd1 << 60;
    end else begin
      a_val = sum[60:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_s2_r  <= m_slat * m_slat;
      m_u_r   <= m_c1 * m_slon;
      m_v_r   <= m_c2 * m_slon;
      neg_u_r <= c1[31] ^ s_lon[31];
      neg_v_r <= c2[31] ^ s_lon[31];
      s2_5_r  <= m_s2_r[60:0];
      u_r     <= neg_u_r ? -$signed({1'b0, r_u[60:30]}) : $signed({1'b0, r_u[60:30]});
      v_r     <= neg_v_r ? -$signed({1'b0, r_v[60:30]}) : $signed({1'b0, r_v[60:30]});
      s2_6_r  <= s2_5_r;
      uv_r    <= u_r * v_r;
      a_r     <= a_val;
      b_r     <= (61'd1 << 60) - a_val;
    end
  end

  logic [30:0] root_a, root_b, phi;

  hdr_isqrt u_sqrt_a (.clk(clk), .en(adv), .v_i(a_r), .root_o(root_a));
  hdr_isqrt u_sqrt_b (.clk(clk), .en(adv), .v_i(b_r), .root_o(root_b));

  hdr_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk(clk), .en(adv), .x_i(root_b), .y_i(root_a), .phi_o(phi)
  );

  // Half the central angle in 2^-32 turn times the distance scale.
  logic [60:0] prod_r;
  logic [61:0] t_dist;
  logic [27:0] dist_r;

  assign t_dist = {1'b0, prod_r} + (62'd1 << 31);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= phi * hdr_pkg::DIST_SCALE;
      dist_r <= (t_dist[61:32] > {2'b00, hdr_pkg::DIST_MAX}) ?
                hdr_pkg::DIST_MAX : t_dist[59:32];
    end
  end

  assign dist_dm = dist_valid ? dist_r : '0;

endmodule

[rtl/core/hdr_checker.sv]
module hdr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 32'd0)
    else $error("nonzero distance on invalid result");

  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 32'd200150868)
    else $error("distance beyond half circumference");

endmodule

bind haversine_distance_to_reference hdr_checker u_hdr_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

[dv/testbench.sv]
module testbench;

  localparam int STAGES = 32;
  localparam int LATENCY = 2 * STAGES + 45;
  localparam longint Q30 = 64'sd1 << 30;
  localparam longint Q60 = 64'sd1 << 60;

  typedef struct packed {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic               ok;
  } fix_t;

  typedef struct packed {
    logic [27:0] dist_dm;
    logic        valid;
  } dist_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  haversine_distance_to_reference #(.CORDIC_STAGES(STAGES)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the reference registers.
  logic        ref_on;
  logic [30:0] ref_lat_q;
  logic [31:0] ref_lon_q;

  fix_t  pending_fixes[$];
  dist_t expected_dists[$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_sender = 1'b0;
  bit    failed = 1'b0;
  bit    in_tready_seen = 1'b0;

  function automatic longint shr_floor(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [31:0] angle_to_phase(longint d, int shift);
    logic [63:0] mag, p;
    logic [31:0] r;
    mag = d < 0 ? -d : d;
    p = (mag * 64'd2562047788 + (64'd1 << (shift - 1))) >> shift;
    r = p[31:0];
    return d < 0 ? -r : r;
  endfunction

  function automatic void rotate_sincos(input logic [31:0] ph, output longint s,
                                        output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed(ph));
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > Q30) begin
      z -= 64'sd1 << 31; flip = 1'b1;
    end else if (z < -Q30) begin
      z += 64'sd1 << 31; flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(hdr_pkg::atan_entry(i));
      end else begin
        x += dx; y -= dy; z += longint'(hdr_pkg::atan_entry(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = clip(y, -Q30, Q30);
    c = clip(x, -Q30, Q30);
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(hdr_pkg::atan_entry(i));
      end else begin
        x -= dx; y += dy; z -= longint'(hdr_pkg::atan_entry(i));
      end
    end
    return clip(z, 0, Q30);
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    longint unsigned ma, mb;
    longint p;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = longint'((ma * mb + (64'd1 << 29)) >> 30);
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 60;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic dist_t great_circle(fix_t f);
    dist_t res;
    longint flat, flon, rlat, rlon, s_lat, s_lon, c1, c2, junk, u, v, a, phi;
    longint unsigned d;
    res = '0;
    if (!(ref_on && f.ok)) return res;
    flat = longint'(f.lat);
    flon = longint'(f.lon);
    rlat = longint'($signed(ref_lat_q));
    rlon = longint'($signed(ref_lon_q));
    rotate_sincos(angle_to_phase(rlat - flat, 32), s_lat, junk);
    rotate_sincos(angle_to_phase(rlon - flon, 32), s_lon, junk);
    rotate_sincos(angle_to_phase(flat, 31), junk, c1);
    rotate_sincos(angle_to_phase(rlat, 31), junk, c2);
    u = q30_mul(c1, s_lon);
    v = q30_mul(c2, s_lon);
    a = clip(s_lat * s_lat + u * v, 0, Q60);
    phi = vector_angle(longint'(floor_sqrt(Q60 - a)), longint'(floor_sqrt(a)));
    d = (longint'(phi) * 64'd800603472 + (64'd1 << 31)) >> 32;
    if (d > hdr_pkg::DIST_MAX) d = hdr_pkg::DIST_MAX;
    res.dist_dm = d[27:0];
    res.valid = 1'b1;
    return res;
  endfunction

  // Driver: a request is offered at the falling edge; valid stays up until taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        // accepted at the last rising edge, already popped by the monitor
      end
      if (!in_tvalid || in_tready_seen) begin
        if (pending_fixes.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {1'b0, pending_fixes[0].lon, pending_fixes[0].lat};
          in_tuser <= pending_fixes[0].ok;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Monitor: requests and results are taken at the rising edge.
  always @(posedge clk) begin
    dist_t got, exp_d;
    in_tready_seen <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_dists.push_back(great_circle(pending_fixes.pop_front()));
      end
      if (out_tvalid && out_tready) begin
        got.dist_dm = out_tdata[27:0];
        got.valid = out_tuser[0];
        if (expected_dists.size() == 0) begin
          $display("%0t: unexpected result actual=%0d/%0b", $time, got.dist_dm, got.valid);
          failed = 1'b1;
        end else begin
          exp_d = expected_dists.pop_front();
          if (got.dist_dm !== exp_d.dist_dm || got.valid !== exp_d.valid) begin
            $display("%0t: distance mismatch expected=%0d/%0b actual=%0d/%0b",
                     $time, exp_d.dist_dm, exp_d.valid, got.dist_dm, got.valid);
            failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic write_reg(input hdr_pkg::cfg_index_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      hdr_pkg::CFG_REF_ENABLE: ref_on = val[0];
      hdr_pkg::CFG_REF_LAT:    ref_lat_q = val[30:0];
      hdr_pkg::CFG_REF_LON:    ref_lon_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_fixes.size() > 0 || expected_dists.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic fix_t random_fix();
    fix_t f;
    case ($urandom_range(5))
      0: begin
        f.lat = 31'($signed($urandom()));
        f.lon = $urandom();
      end
      1: begin
        f.lat = ref_lat_q + 31'($signed($urandom_range(2000)) - 1000);
        f.lon = ref_lon_q + 32'($signed($urandom_range(2000)) - 1000);
      end
      2: begin
        f.lat = -$signed(ref_lat_q);
        f.lon = ref_lon_q + 32'd1800000000;
      end
      default: begin
        f.lat = 31'($signed($urandom_range(1800000000)) - 900000000);
        f.lon = $urandom_range(2000000000) + $urandom_range(1600000000);
        f.lon = f.lon - 32'd1800000000;
      end
    endcase
    f.ok = $urandom_range(9) != 0;
    return f;
  endfunction

  task automatic add_fix(input logic [30:0] lat, input logic [31:0] lon, input logic ok);
    fix_t f;
    f.lat = lat; f.lon = lon; f.ok = ok;
    pending_fixes.push_back(f);
  endtask

  initial begin
    ref_on = 1'b0;
    ref_lat_q = '0;
    ref_lon_q = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reference still disabled: every result must be zero and invalid.
    add_fix(31'd123456789, 32'd987654321, 1'b1);
    add_fix('0, '0, 1'b0);
    drain();

    write_reg(hdr_pkg::CFG_REF_ENABLE, 32'd1);
    write_reg(hdr_pkg::CFG_REF_LAT, 32'(-31'sd900000000));
    write_reg(hdr_pkg::CFG_REF_LON, 32'(-32'sd1800000000));
    // Extremes of both fields, antipodes, the same point, out-of-range angles.
    add_fix(31'sd900000000, 32'sd1800000000, 1'b1);
    add_fix(-31'sd900000000, -32'sd1800000000, 1'b1);
    add_fix(31'sd900000000, '0, 1'b1);
    add_fix('0, '0, 1'b1);
    add_fix(31'h3fffffff, 32'h7fffffff, 1'b1);
    add_fix(31'h40000000, 32'h80000000, 1'b1);
    add_fix(31'h7fffffff, 32'hffffffff, 1'b1);
    add_fix(31'sd900000000, 32'sd1800000000, 1'b0);
    drain();

    write_reg(hdr_pkg::CFG_REF_LAT, 32'd0);
    write_reg(hdr_pkg::CFG_REF_LON, 32'd0);
    add_fix('0, 32'sd1800000000, 1'b1);
    add_fix('0, -32'sd1800000000, 1'b1);
    add_fix('0, 32'sd900000000, 1'b1);
    add_fix(31'sd450000000, 32'sd1, 1'b1);
    add_fix(31'sd1, '0, 1'b1);
    add_fix(31'h40000000, 32'h80000000, 1'b1);
    drain();

    write_reg(hdr_pkg::CFG_REF_LAT, 32'h3fffffff);
    write_reg(hdr_pkg::CFG_REF_LON, 32'h7fffffff);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int k = 0; k < 160; k++) begin
        if (k == 80 && phase == 2) begin
          // Let the pipeline empty completely before carrying on.
          hold_sender = 1'b1;
          while (expected_dists.size() > 0 || in_tvalid) @(posedge clk);
          hold_sender = 1'b0;
        end
        pending_fixes.push_back(random_fix());
      end
      drain();
      write_reg(hdr_pkg::CFG_REF_ENABLE, 32'(phase != 3));
      write_reg(hdr_pkg::CFG_REF_LAT, 32'($signed($urandom_range(1800000000)) - 900000000));
      write_reg(hdr_pkg::CFG_REF_LON, $urandom());
    end

    if (!failed) begin
      $display("haversine_distance_to_reference verification clean");
    end else begin
      $display("haversine_distance_to_reference verification failed");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("haversine_distance_to_reference verification failed");
    $finish;
  end

endmodule
